### hdl/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/idgw_pkg.sv
// types and constants for the inverse-distance grid weights pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package idgw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = FRAC_BITS + 13;
  localparam int DIM_W     = 13;
  localparam int IDX_W     = 12;
  localparam int OFF_W     = 25;
  localparam int WT_W      = FRAC_BITS + 1;
  localparam int DLT_W     = FRAC_BITS + 1;
  localparam int SQ_W      = 2 * FRAC_BITS + 1;
  localparam int D2_W      = 2 * FRAC_BITS + 2;
  localparam int ROOT_W    = FRAC_BITS + 1;
  localparam int SREM_W    = ROOT_W + 3;
  localparam int DREM_W    = ROOT_W + 1;
  localparam int INV_SHIFT = 60;
  localparam int QUO_W     = INV_SHIFT + 1;
  localparam int SUM_W     = INV_SHIFT + 3;
  localparam int FR_W      = SUM_W + 1;
  localparam int CIDX_W    = 2;

  localparam logic [DIM_W-1:0] MAX_GRID_DIM = DIM_W'(4096);
  localparam logic [DLT_W-1:0] ONE          = DLT_W'(1) << FRAC_BITS;

  localparam logic [CIDX_W-1:0] REG_GRID_COLUMNS = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_GRID_ROWS    = CIDX_W'(1);

  // pipeline layout
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int SQRT_PER    = 2;
  localparam int SQRT_STAGES = (SQRT_STEPS + SQRT_PER - 1) / SQRT_PER;
  localparam int DIV_STEPS   = QUO_W;
  localparam int DIV_PER     = 4;
  localparam int DIV_STAGES  = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
  localparam int FRAC_STEPS  = FRAC_BITS + 1;

  localparam int ST_CAP   = 0;
  localparam int ST_SQ    = 1;
  localparam int ST_D2    = 2;
  localparam int ST_SQRT0 = 3;
  localparam int ST_DIV0  = ST_SQRT0 + SQRT_STAGES;
  localparam int ST_SUMA  = ST_DIV0 + DIV_STAGES;
  localparam int ST_SUMB  = ST_SUMA + 1;
  localparam int ST_FRAC0 = ST_SUMB + 1;
  localparam int ST_OUT   = ST_FRAC0 + FRAC_STEPS;
  localparam int NUM_ST   = ST_OUT + 1;

  typedef struct packed {
    logic                         set;
    logic [3:0]                   zero;
    logic [IDX_W-1:0]             ix;
    logic [IDX_W-1:0]             iy;
    logic [DIM_W-1:0]             nx;
    logic [FRAC_BITS-1:0]         fx;
    logic [FRAC_BITS-1:0]         fy;
    logic [OFF_W-1:0]             prod;
    logic [3:0][OFF_W-1:0]        off;
    logic [3:0][SQ_W-1:0]         sqa;
    logic [3:0][SQ_W-1:0]         sqb;
    logic [3:0][D2_W-1:0]         d2;
    logic [3:0][SREM_W-1:0]       srem;
    logic [3:0][ROOT_W-1:0]       root;
    logic [3:0][DREM_W-1:0]       drem;
    logic [3:0][QUO_W-1:0]        quo;
    logic [SUM_W-1:0]             sa;
    logic [SUM_W-1:0]             sb;
    logic [SUM_W-1:0]             den;
    logic [3:0][FR_W-1:0]         fr;
    logic [3:0][WT_W-1:0]         q;
  } item_t;

endpackage

`default_nettype wire

### hdl/inverse_distance_grid_weights_unit.sv
// inverse-distance weights for the four grid cells around a sample point
// pipelined top level; depends on idgw_pkg
//
// usage
//   configuration: cfg_wr_en with cfg_index and cfg_wdata writes grid_columns
//   (index 0) or grid_rows (index 1); other indexes are ignored. write only
//   while no transaction is in flight.
//   input channel: in_valid / in_stall carry x_pos, y_pos and position_ok.
//   output channel: out_valid / out_stall carry entry_set, the four offsets
//   and the four weights.
//   pipeline: 48 register stages, the first loaded at the accepting edge; the
//   result shows on out_valid when it reaches the last of them.
//   throughput: one transaction per cycle while no stall holds the pipeline;
//   the 48-stage pipeline is bounded by the 61-step reciprocal and the
//   17-step normalizing divider, each cut into per-stage slices.
//   reset: pipeline valid bits clear, both grid registers return to 1.
//   stall: while the result register holds a transaction and out_stall is
//   high, the whole pipeline holds and in_stall is raised; nothing is lost
//   or repeated.
`timescale 1ns / 1ps
`default_nettype none

module inverse_distance_grid_weights_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [idgw_pkg::CIDX_W-1:0]         cfg_index,
  input  wire logic [idgw_pkg::DIM_W-1:0]          cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [idgw_pkg::POS_W-1:0]   in_x_pos,
  input  wire logic signed [idgw_pkg::POS_W-1:0]   in_y_pos,
  input  wire logic                                in_position_ok,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_entry_set,
  output logic [idgw_pkg::OFF_W-1:0]               out_offset_sw,
  output logic [idgw_pkg::OFF_W-1:0]               out_offset_se,
  output logic [idgw_pkg::OFF_W-1:0]               out_offset_ne,
  output logic [idgw_pkg::OFF_W-1:0]               out_offset_nw,
  output logic [idgw_pkg::WT_W-1:0]                out_weight_sw,
  output logic [idgw_pkg::WT_W-1:0]                out_weight_se,
  output logic [idgw_pkg::WT_W-1:0]                out_weight_ne,
  output logic [idgw_pkg::WT_W-1:0]                out_weight_nw
);

  localparam int NST = idgw_pkg::NUM_ST;
  localparam int FB  = idgw_pkg::FRAC_BITS;

  logic [idgw_pkg::DIM_W-1:0] cols_r;
  logic [idgw_pkg::DIM_W-1:0] rows_r;
  logic                       adv;
  logic [NST-1:0]             vld_r;
  idgw_pkg::item_t            pipe_r [NST];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= idgw_pkg::DIM_W'(1);
      rows_r <= idgw_pkg::DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        idgw_pkg::REG_GRID_COLUMNS: cols_r <= cfg_wdata;
        idgw_pkg::REG_GRID_ROWS:    rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = ~(vld_r[NST-1] & out_stall);
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    idgw_pkg::item_t nxt;

    if (s == idgw_pkg::ST_CAP) begin : g_cap
      always_comb begin
        logic [idgw_pkg::DIM_W-1:0] nx;
        logic [idgw_pkg::DIM_W-1:0] ny;
        logic [idgw_pkg::DIM_W-1:0] nxm;
        logic [idgw_pkg::DIM_W-1:0] nym;
        logic                       in_x;
        logic                       in_y;
        nx  = (cols_r > idgw_pkg::MAX_GRID_DIM) ? idgw_pkg::MAX_GRID_DIM : cols_r;
        ny  = (rows_r > idgw_pkg::MAX_GRID_DIM) ? idgw_pkg::MAX_GRID_DIM : rows_r;
        nxm = nx - idgw_pkg::DIM_W'(1);
        nym = ny - idgw_pkg::DIM_W'(1);
        in_x = ~in_x_pos[idgw_pkg::POS_W-1] &&
               (in_x_pos[idgw_pkg::POS_W-2:0] <= {nxm[idgw_pkg::IDX_W-1:0], FB'(0)});
        in_y = ~in_y_pos[idgw_pkg::POS_W-1] &&
               (in_y_pos[idgw_pkg::POS_W-2:0] <= {nym[idgw_pkg::IDX_W-1:0], FB'(0)});
        nxt     = '0;
        nxt.set = in_position_ok && (nx != '0) && (ny != '0) && in_x && in_y;
        nxt.ix  = in_x_pos[idgw_pkg::POS_W-2:FB];
        nxt.iy  = in_y_pos[idgw_pkg::POS_W-2:FB];
        nxt.fx  = in_x_pos[FB-1:0];
        nxt.fy  = in_y_pos[FB-1:0];
        nxt.nx  = nx;
      end
    end else if (s == idgw_pkg::ST_SQ) begin : g_sq
      always_comb begin
        logic [idgw_pkg::DLT_W-1:0]   dx;
        logic [idgw_pkg::DLT_W-1:0]   dy;
        logic [2*idgw_pkg::DLT_W-1:0] pa;
        logic [2*idgw_pkg::DLT_W-1:0] pb;
        nxt = pipe_r[s-1];
        for (int k = 0; k < 4; k++) begin
          dx = (k == 1 || k == 2) ? idgw_pkg::ONE - {1'b0, pipe_r[s-1].fx}
                                  : {1'b0, pipe_r[s-1].fx};
          dy = (k >= 2) ? idgw_pkg::ONE - {1'b0, pipe_r[s-1].fy}
                        : {1'b0, pipe_r[s-1].fy};
          pa = dx * dx;
          pb = dy * dy;
          nxt.sqa[k] = pa[idgw_pkg::SQ_W-1:0];
          nxt.sqb[k] = pb[idgw_pkg::SQ_W-1:0];
        end
        nxt.prod = pipe_r[s-1].iy * pipe_r[s-1].nx;
      end
    end else if (s == idgw_pkg::ST_D2) begin : g_d2
      always_comb begin
        logic [idgw_pkg::OFF_W-1:0] base;
        nxt = pipe_r[s-1];
        for (int k = 0; k < 4; k++) begin
          nxt.d2[k]   = {1'b0, pipe_r[s-1].sqa[k]} + {1'b0, pipe_r[s-1].sqb[k]};
          nxt.zero[k] = (nxt.d2[k] == '0);
          nxt.srem[k] = '0;
          nxt.root[k] = '0;
          nxt.drem[k] = '0;
          nxt.quo[k]  = '0;
        end
        base       = pipe_r[s-1].prod + idgw_pkg::OFF_W'(pipe_r[s-1].ix);
        nxt.off[0] = base;
        nxt.off[1] = base + idgw_pkg::OFF_W'(1);
        nxt.off[2] = base + idgw_pkg::OFF_W'(1) + idgw_pkg::OFF_W'(pipe_r[s-1].nx);
        nxt.off[3] = base + idgw_pkg::OFF_W'(pipe_r[s-1].nx);
      end
    end else if (s < idgw_pkg::ST_DIV0) begin : g_sqrt
      // integer square root, two result bits per stage (one in the last)
      always_comb begin
        logic [idgw_pkg::SREM_W-1:0] rem;
        logic [idgw_pkg::SREM_W-1:0] trial;
        nxt = pipe_r[s-1];
        for (int j = 0; j < idgw_pkg::SQRT_PER; j++) begin
          if ((s - idgw_pkg::ST_SQRT0) * idgw_pkg::SQRT_PER + j < idgw_pkg::SQRT_STEPS) begin
            for (int k = 0; k < 4; k++) begin
              rem   = {nxt.srem[k][idgw_pkg::SREM_W-3:0],
                       nxt.d2[k][idgw_pkg::D2_W-1:idgw_pkg::D2_W-2]};
              trial = {1'b0, nxt.root[k], 2'b01};
              nxt.d2[k] = {nxt.d2[k][idgw_pkg::D2_W-3:0], 2'b00};
              if (rem >= trial) begin
                nxt.srem[k] = rem - trial;
                nxt.root[k] = {nxt.root[k][idgw_pkg::ROOT_W-2:0], 1'b1};
              end else begin
                nxt.srem[k] = rem;
                nxt.root[k] = {nxt.root[k][idgw_pkg::ROOT_W-2:0], 1'b0};
              end
            end
          end
        end
      end
    end else if (s < idgw_pkg::ST_SUMA) begin : g_div
      // 2^60 / distance, four quotient bits per stage (one in the last)
      always_comb begin
        logic [idgw_pkg::ROOT_W-1:0] dv;
        logic [idgw_pkg::DREM_W-1:0] r;
        logic                        bin;
        nxt = pipe_r[s-1];
        for (int j = 0; j < idgw_pkg::DIV_PER; j++) begin
          if ((s - idgw_pkg::ST_DIV0) * idgw_pkg::DIV_PER + j < idgw_pkg::DIV_STEPS) begin
            bin = ((s - idgw_pkg::ST_DIV0) * idgw_pkg::DIV_PER + j == 0);
            for (int k = 0; k < 4; k++) begin
              dv = (nxt.root[k] == '0) ? idgw_pkg::ROOT_W'(1) : nxt.root[k];
              r  = {nxt.drem[k][idgw_pkg::DREM_W-2:0], bin};
              if (r >= {1'b0, dv}) begin
                nxt.drem[k] = r - {1'b0, dv};
                nxt.quo[k]  = {nxt.quo[k][idgw_pkg::QUO_W-2:0], 1'b1};
              end else begin
                nxt.drem[k] = r;
                nxt.quo[k]  = {nxt.quo[k][idgw_pkg::QUO_W-2:0], 1'b0};
              end
            end
          end
        end
      end
    end else if (s == idgw_pkg::ST_SUMA) begin : g_suma
      always_comb begin
        nxt = pipe_r[s-1];
        for (int k = 0; k < 4; k++) begin
          nxt.fr[k] = pipe_r[s-1].zero[k] ? '0 : idgw_pkg::FR_W'(pipe_r[s-1].quo[k]);
        end
        nxt.sa = nxt.fr[0][idgw_pkg::SUM_W-1:0] + nxt.fr[1][idgw_pkg::SUM_W-1:0];
        nxt.sb = nxt.fr[2][idgw_pkg::SUM_W-1:0] + nxt.fr[3][idgw_pkg::SUM_W-1:0];
      end
    end else if (s == idgw_pkg::ST_SUMB) begin : g_sumb
      always_comb begin
        nxt     = pipe_r[s-1];
        nxt.den = pipe_r[s-1].sa + pipe_r[s-1].sb;
        nxt.q   = '0;
      end
    end else if (s < idgw_pkg::ST_OUT) begin : g_frac
      // normalizing divider, one weight bit per stage
      always_comb begin
        logic [idgw_pkg::FR_W-1:0] r;
        nxt = pipe_r[s-1];
        for (int k = 0; k < 4; k++) begin
          r = (s == idgw_pkg::ST_FRAC0) ? pipe_r[s-1].fr[k]
                                        : {pipe_r[s-1].fr[k][idgw_pkg::FR_W-2:0], 1'b0};
          nxt.q[k] = (s == idgw_pkg::ST_FRAC0) ? pipe_r[s-1].q[k]
                                               : {pipe_r[s-1].q[k][idgw_pkg::WT_W-2:0], 1'b0};
          if (r >= {1'b0, pipe_r[s-1].den}) begin
            r        = r - {1'b0, pipe_r[s-1].den};
            nxt.q[k] = nxt.q[k] | idgw_pkg::WT_W'(1);
          end
          nxt.fr[k] = r;
        end
      end
    end else begin : g_out
      always_comb begin
        nxt = pipe_r[s-1];
        for (int k = 0; k < 4; k++) begin
          if (!pipe_r[s-1].set) begin
            nxt.q[k]   = '0;
            nxt.off[k] = '0;
          end else if (pipe_r[s-1].zero != '0) begin
            nxt.q[k] = pipe_r[s-1].zero[k] ? idgw_pkg::WT_W'(idgw_pkg::ONE) : '0;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[s] <= nxt;
      end
    end
  end

  assign out_valid     = vld_r[NST-1];
  assign out_entry_set = pipe_r[NST-1].set;
  assign out_offset_sw = pipe_r[NST-1].off[0];
  assign out_offset_se = pipe_r[NST-1].off[1];
  assign out_offset_ne = pipe_r[NST-1].off[2];
  assign out_offset_nw = pipe_r[NST-1].off[3];
  assign out_weight_sw = pipe_r[NST-1].q[0];
  assign out_weight_se = pipe_r[NST-1].q[1];
  assign out_weight_ne = pipe_r[NST-1].q[2];
  assign out_weight_nw = pipe_r[NST-1].q[3];

endmodule

`default_nettype wire

### hdl/idgw_checker.sv
// port-level checks for the inverse-distance grid weights unit, with bind
// depends on idgw_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module idgw_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              out_entry_set,
  input wire logic [idgw_pkg::OFF_W-1:0]        out_offset_sw,
  input wire logic [idgw_pkg::OFF_W-1:0]        out_offset_se,
  input wire logic [idgw_pkg::OFF_W-1:0]        out_offset_ne,
  input wire logic [idgw_pkg::OFF_W-1:0]        out_offset_nw,
  input wire logic [idgw_pkg::WT_W-1:0]         out_weight_sw,
  input wire logic [idgw_pkg::WT_W-1:0]         out_weight_se,
  input wire logic [idgw_pkg::WT_W-1:0]         out_weight_ne,
  input wire logic [idgw_pkg::WT_W-1:0]         out_weight_nw
);

  logic [idgw_pkg::WT_W+1:0] wsum;

  assign wsum = (idgw_pkg::WT_W+2)'(out_weight_sw) + (idgw_pkg::WT_W+2)'(out_weight_se) +
                (idgw_pkg::WT_W+2)'(out_weight_ne) + (idgw_pkg::WT_W+2)'(out_weight_nw);

  // stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_weight_sw) && $stable(out_offset_sw), "stalled result changed")
  // input is only held back by a stalled result
  `ASSERT_IMPLY(a_no_idle_stall, clk, rst_n, !out_valid || !out_stall, !in_stall, "input stalled without cause")
  // unusable point gives zero south-west and north-west offsets and zero weights
  `ASSERT_IMPLY(a_zero_fields, clk, rst_n, out_valid && !out_entry_set, out_offset_sw == '0 && out_offset_nw == '0 && wsum == '0, "nonzero fields without entry")
  // south-east offset follows the south-west one, north-east the north-west one
  `ASSERT_IMPLY(a_offsets, clk, rst_n, out_valid && out_entry_set, out_offset_se == out_offset_sw + idgw_pkg::OFF_W'(1) && out_offset_ne - out_offset_nw == idgw_pkg::OFF_W'(1), "offset relation broken")
  // weights of a set entry never add to more than one, nor to zero
  `ASSERT_IMPLY(a_wsum, clk, rst_n, out_valid && out_entry_set, wsum <= (idgw_pkg::WT_W+2)'(idgw_pkg::ONE) && wsum != '0, "weight sum out of range")

endmodule

bind inverse_distance_grid_weights_unit idgw_checker u_idgw_checker (.*);

`default_nettype wire
